// File: hdl/pol_pkg.sv
package pol_pkg;

   localparam int CAPACITY   = 32;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   typedef logic [DATA_WIDTH-1:0] data_type;
   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [CNT_W-1:0]      count_type;

   // operation codes
   localparam logic [2:0] MODE_INS_FRONT = 3'd0;
   localparam logic [2:0] MODE_INS_BACK  = 3'd1;
   localparam logic [2:0] MODE_INS_POS   = 3'd2;
   localparam logic [2:0] MODE_DEL_FRONT = 3'd3;
   localparam logic [2:0] MODE_DEL_BACK  = 3'd4;
   localparam logic [2:0] MODE_DEL_POS   = 3'd5;
   localparam logic [2:0] MODE_READ_OUT  = 3'd6;
   localparam logic [2:0] MODE_NONE      = 3'd7;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BADPOS = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_EMPTY  = 2'd3;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] value;
      logic [7:0]  position;
   } req_word_type;

   typedef struct packed {
      logic [31:0] element;
      logic        element_valid;
      logic [5:0]  item_count;
      logic [1:0]  status;
      logic        last;
   } rsp_word_type;

endpackage

// File: hdl/pol_ram.sv
module pol_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/positional_ordered_list.sv
// Ordered list of up to CAPACITY words held in one synchronous RAM.
// Request channel (req_valid / req_stall / req_word) takes one operation:
// insert front, back or at a 1-based position, delete front, back or at a
// position, or a read-out. Response channel (rsp_valid / rsp_stall /
// rsp_word) gives one word per mutation with new count and status, and
// one word per entry on a read-out (a single empty word if the list is
// empty); the final word of each operation has last set.
// A mutation's response is registered on accept. Entries are moved
// through the single RAM port pair, read in one state, written in the
// next: an insert at slot i shifts slots i and up by one, then writes
// the new word; a delete at slot i shifts the slots above it down; at
// the back neither shifts. A read-out hands on each entry as the
// response register frees up. New requests are held off while a move or
// read-out runs, and while the response register is full and stalled.
// Reset empties the list (count to zero); RAM contents are not cleared.
// A stalled response word holds unchanged until taken.
module positional_ordered_list (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pol_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pol_pkg::rsp_word_type rsp_word
);

   typedef enum logic [2:0] {
      S_IDLE, S_UP_RD, S_UP_WR, S_INS, S_DN_RD, S_DN_WR, S_RO_RD, S_RO_WR
   } state_type;

   state_type             state_ff, state_in;
   pol_pkg::count_type    count_ff, count_in;
   pol_pkg::addr_type     ptr_ff, ptr_in;
   pol_pkg::addr_type     stop_ff, stop_in;
   pol_pkg::data_type     value_ff, value_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   pol_pkg::rsp_word_type rsp_ff, rsp_in;

   logic              wr_en, rd_en;
   pol_pkg::addr_type wr_addr, rd_addr;
   pol_pkg::data_type wr_data, rd_data;

   logic       rsp_free, accept;
   logic       full, empty, do_ins, do_del, do_ro;
   logic [8:0] cnt9, pos9, idx9;
   logic [1:0] status;

   pol_ram #(.DEPTH(pol_pkg::CAPACITY), .WIDTH(pol_pkg::DATA_WIDTH)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !rsp_free;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // decode the request against the current count
   always_comb begin
      cnt9   = 9'(count_ff);
      pos9   = 9'(req_word.position);
      full   = (cnt9 >= 9'(pol_pkg::CAPACITY));
      empty  = (count_ff == '0);
      do_ins = 1'b0;
      do_del = 1'b0;
      do_ro  = 1'b0;
      idx9   = '0;
      status = pol_pkg::ST_OK;
      unique case (req_word.mode)
         pol_pkg::MODE_INS_FRONT: begin
            if (full) status = pol_pkg::ST_FULL;
            else do_ins = 1'b1;
         end
         pol_pkg::MODE_INS_BACK: begin
            idx9 = cnt9;
            if (full) status = pol_pkg::ST_FULL;
            else do_ins = 1'b1;
         end
         pol_pkg::MODE_INS_POS: begin
            idx9 = pos9 - 9'd1;
            if (pos9 == 9'd0 || pos9 > cnt9 + 9'd1) status = pol_pkg::ST_BADPOS;
            else if (full) status = pol_pkg::ST_FULL;
            else do_ins = 1'b1;
         end
         pol_pkg::MODE_DEL_FRONT: begin
            if (empty) status = pol_pkg::ST_EMPTY;
            else do_del = 1'b1;
         end
         pol_pkg::MODE_DEL_BACK: begin
            idx9 = cnt9 - 9'd1;
            if (empty) status = pol_pkg::ST_EMPTY;
            else do_del = 1'b1;
         end
         pol_pkg::MODE_DEL_POS: begin
            idx9 = pos9 - 9'd1;
            if (pos9 == 9'd0 || pos9 > cnt9) status = pol_pkg::ST_BADPOS;
            else do_del = 1'b1;
         end
         pol_pkg::MODE_READ_OUT: begin
            if (empty) status = pol_pkg::ST_EMPTY;
            else do_ro = 1'b1;
         end
         default: status = pol_pkg::ST_OK;
      endcase
   end

   // sequencer: RAM port control and next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      stop_in      = stop_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff;
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               value_in = pol_pkg::data_type'(req_word.value);
               if (!do_ro) begin
                  // one response word per mutation, sent right away
                  if (do_ins) count_in = count_ff + 1'b1;
                  if (do_del) count_in = count_ff - 1'b1;
                  rsp_valid_in          = 1'b1;
                  rsp_in.element        = '0;
                  rsp_in.element_valid  = 1'b0;
                  rsp_in.item_count     = 6'(do_ins ? count_ff + 1'b1 :
                                              do_del ? count_ff - 1'b1 : count_ff);
                  rsp_in.status         = status;
                  rsp_in.last           = 1'b1;
               end
               if (do_ins) begin
                  if (idx9 == cnt9) begin
                     wr_en   = 1'b1;
                     wr_addr = pol_pkg::addr_type'(idx9);
                     wr_data = pol_pkg::data_type'(req_word.value);
                  end else begin
                     ptr_in   = pol_pkg::addr_type'(cnt9);
                     stop_in  = pol_pkg::addr_type'(idx9);
                     state_in = S_UP_RD;
                  end
               end
               if (do_del && idx9 != cnt9 - 9'd1) begin
                  ptr_in   = pol_pkg::addr_type'(idx9);
                  stop_in  = pol_pkg::addr_type'(cnt9 - 9'd1);
                  state_in = S_DN_RD;
               end
               if (do_ro) begin
                  ptr_in   = '0;
                  stop_in  = pol_pkg::addr_type'(cnt9 - 9'd1);
                  state_in = S_RO_RD;
               end
            end
         end
         S_UP_RD: begin
            rd_en    = 1'b1;
            rd_addr  = ptr_ff - 1'b1;
            state_in = S_UP_WR;
         end
         S_UP_WR: begin
            wr_en = 1'b1;
            if (ptr_ff - 1'b1 == stop_ff) begin
               state_in = S_INS;
            end else begin
               ptr_in   = ptr_ff - 1'b1;
               state_in = S_UP_RD;
            end
         end
         S_INS: begin
            wr_en    = 1'b1;
            wr_addr  = stop_ff;
            wr_data  = value_ff;
            state_in = S_IDLE;
         end
         S_DN_RD: begin
            rd_en    = 1'b1;
            rd_addr  = ptr_ff + 1'b1;
            state_in = S_DN_WR;
         end
         S_DN_WR: begin
            wr_en = 1'b1;
            if (ptr_ff + 1'b1 == stop_ff) begin
               state_in = S_IDLE;
            end else begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = S_DN_RD;
            end
         end
         S_RO_RD: begin
            rd_en    = 1'b1;
            state_in = S_RO_WR;
         end
         S_RO_WR: begin
            // hold the read word until the response register frees up
            if (rsp_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.element       = 32'(rd_data);
               rsp_in.element_valid = 1'b1;
               rsp_in.item_count    = 6'(count_ff);
               rsp_in.status        = pol_pkg::ST_OK;
               rsp_in.last          = (ptr_ff == stop_ff);
               if (ptr_ff == stop_ff) begin
                  state_in = S_IDLE;
               end else begin
                  ptr_in   = ptr_ff + 1'b1;
                  state_in = S_RO_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff   <= ptr_in;
      stop_ff  <= stop_in;
      value_ff <= value_in;
      rsp_ff   <= rsp_in;
   end

endmodule

// File: hdl/pol_checker.sv
module pol_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input pol_pkg::rsp_word_type rsp_word
);

   // a stalled response word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // count never passes capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.item_count <= 6'(pol_pkg::CAPACITY))
      else $error("item count beyond capacity");

   // an element word always carries ok status
   a_elem_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.element_valid |-> rsp_word.status == pol_pkg::ST_OK)
      else $error("element word with error status");

   // non-element words carry a zero element and have last set
   a_elem_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.element_valid |-> rsp_word.element == '0 && rsp_word.last)
      else $error("non-element word malformed");

endmodule

bind positional_ordered_list pol_checker u_pol_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_word (rsp_word)
);
